// ----- src/tga_image_stream_decoder_top_defines.svh -----
// ----------------------------------------------------------------------------
// TGA decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef TGA_IMAGE_STREAM_DECODER_TOP_DEFINES_SVH
`define TGA_IMAGE_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define TGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tga_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// TGA decoder package
// Result type, status codes and channel counts shared by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_dec_pkg;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_COLOR_MAPPED = 2'd1,
    ST_BAD_DEPTH    = 2'd2,
    ST_TRUNCATED    = 2'd3
  } status_t;

  localparam logic [2:0] CHANNELS_RGB  = 3'd3;
  localparam logic [2:0] CHANNELS_RGBA = 3'd4;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_count;
    logic        last_pixel;
    status_t     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  channel_count;
  } result_t;

endpackage

`default_nettype wire

// ----- src/tga_dec_core.sv -----
// ----------------------------------------------------------------------------
// TGA decoder core
// Header parser, skip counter, RLE packet tracking and pixel assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_dec_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 frame_start,
  input  wire logic                 file_end,
  output logic                      res_valid,
  output tga_dec_pkg::result_t      res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PACKET,
    PH_RLE_PIXEL,
    PH_DONE
  } phase_t;

  localparam logic [4:0] HDR_ID_LEN      = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE   = 5'd1;
  localparam logic [4:0] HDR_IMAGE_TYPE  = 5'd2;
  localparam logic [4:0] HDR_CMAP_LEN_LO = 5'd5;
  localparam logic [4:0] HDR_CMAP_LEN_HI = 5'd6;
  localparam logic [4:0] HDR_CMAP_DEPTH  = 5'd7;
  localparam logic [4:0] HDR_WIDTH_LO    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI    = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO   = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI   = 5'd15;
  localparam logic [4:0] HDR_DEPTH       = 5'd16;
  localparam logic [4:0] HDR_LAST        = 5'd17;
  localparam logic [7:0] IMG_TYPE_RLE    = 8'd10;
  localparam logic [7:0] DEPTH_16        = 8'd16;
  localparam logic [7:0] DEPTH_24        = 8'd24;
  localparam logic [7:0] DEPTH_32        = 8'd32;

  // state
  phase_t      phase;
  logic [4:0]  header_index;
  logic [7:0]  id_field_length;
  logic [7:0]  compression_kind;
  logic [15:0] palette_entries;
  logic [7:0]  palette_entry_bits;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  pixel_depth;
  logic [20:0] skip_remaining;
  logic [31:0] pixels_left;
  logic [7:0]  packet_left;
  logic        packet_is_run;
  logic [31:0] color_assembly;
  logic [1:0]  color_byte_index;
  // products worked out at the depth byte, used one byte later
  logic [31:0] pixel_total;
  logic [20:0] skip_total;

  phase_t      phase_next;
  logic [4:0]  header_index_next;
  logic [7:0]  id_field_length_next;
  logic [7:0]  compression_kind_next;
  logic [15:0] palette_entries_next;
  logic [7:0]  palette_entry_bits_next;
  logic [15:0] width_reg_next;
  logic [15:0] height_reg_next;
  logic [7:0]  pixel_depth_next;
  logic [20:0] skip_remaining_next;
  logic [31:0] pixels_left_next;
  logic [7:0]  packet_left_next;
  logic        packet_is_run_next;
  logic [31:0] color_assembly_next;
  logic [1:0]  color_byte_index_next;
  logic [31:0] pixel_total_next;
  logic [20:0] skip_total_next;

  // state seen by this byte (frame_start wipes it first)
  phase_t      e_phase;
  logic [4:0]  e_header_index;
  logic [7:0]  e_compression_kind;
  logic [7:0]  e_pixel_depth;
  logic [31:0] e_pixels_left;
  logic [7:0]  e_packet_left;
  logic        e_packet_is_run;
  logic [31:0] e_color_assembly;
  logic [1:0]  e_color_byte_index;
  logic [20:0] e_skip_remaining;

  logic [31:0] asm_word;
  logic [4:0]  byte_count;
  logic        pix_done;
  logic        is_rle;
  logic        depth_ok;
  phase_t      pix_phase;
  logic [7:0]  pkt_len;
  logic [31:0] pixel_prod;
  logic [20:0] skip_prod;

  logic        have;
  logic        last;
  tga_dec_pkg::status_t st;
  logic [7:0]  r_val;
  logic [7:0]  g_val;
  logic [7:0]  b_val;
  logic [7:0]  a_val;
  logic [7:0]  cnt;

  always_comb begin
    e_phase            = frame_start ? PH_HEADER : phase;
    e_header_index     = frame_start ? 5'd0  : header_index;
    e_compression_kind = frame_start ? 8'd0  : compression_kind;
    e_pixel_depth      = frame_start ? 8'd0  : pixel_depth;
    e_pixels_left      = frame_start ? 32'd0 : pixels_left;
    e_packet_left      = frame_start ? 8'd0  : packet_left;
    e_packet_is_run    = frame_start ? 1'b0  : packet_is_run;
    e_color_assembly   = frame_start ? 32'd0 : color_assembly;
    e_color_byte_index = frame_start ? 2'd0  : color_byte_index;
    e_skip_remaining   = frame_start ? 21'd0 : skip_remaining;

    phase_next              = e_phase;
    header_index_next       = e_header_index;
    id_field_length_next    = frame_start ? 8'd0  : id_field_length;
    compression_kind_next   = e_compression_kind;
    palette_entries_next    = frame_start ? 16'd0 : palette_entries;
    palette_entry_bits_next = frame_start ? 8'd0  : palette_entry_bits;
    width_reg_next          = frame_start ? 16'd0 : width_reg;
    height_reg_next         = frame_start ? 16'd0 : height_reg;
    pixel_depth_next        = e_pixel_depth;
    skip_remaining_next     = e_skip_remaining;
    pixels_left_next        = e_pixels_left;
    packet_left_next        = e_packet_left;
    packet_is_run_next      = e_packet_is_run;
    color_assembly_next     = e_color_assembly;
    color_byte_index_next   = e_color_byte_index;
    pixel_total_next        = pixel_total;
    skip_total_next         = skip_total;

    have  = 1'b0;
    last  = 1'b0;
    st    = tga_dec_pkg::ST_OK;
    r_val = 8'd0;
    g_val = 8'd0;
    b_val = 8'd0;
    a_val = 8'd0;
    cnt   = 8'd0;

    asm_word   = e_color_assembly | ({24'd0, data_byte} << {e_color_byte_index, 3'b000});
    byte_count = {3'd0, e_color_byte_index} + 5'd1;
    pix_done   = (byte_count >= e_pixel_depth[7:3]);
    is_rle     = (e_compression_kind == IMG_TYPE_RLE);
    depth_ok   = (e_pixel_depth == DEPTH_24) || (e_pixel_depth == DEPTH_32) ||
                 (!is_rle && (e_pixel_depth == DEPTH_16));
    pix_phase  = is_rle ? PH_PACKET : PH_PIXEL;
    pkt_len    = {1'b0, data_byte[6:0]} + 8'd1;
    pixel_prod = {16'd0, width_reg} * {16'd0, height_reg};
    skip_prod  = {5'd0, palette_entries} * {16'd0, palette_entry_bits[7:3]};

    case (e_phase)
      PH_HEADER: begin
        case (e_header_index)
          HDR_ID_LEN:      id_field_length_next = data_byte;
          HDR_CMAP_TYPE: begin
            if (data_byte != 8'd0) begin
              have       = 1'b1;
              last       = 1'b1;
              st         = tga_dec_pkg::ST_COLOR_MAPPED;
              phase_next = PH_DONE;
            end
          end
          HDR_IMAGE_TYPE:  compression_kind_next = data_byte;
          HDR_CMAP_LEN_LO: palette_entries_next[7:0] = data_byte;
          HDR_CMAP_LEN_HI: palette_entries_next[15:8] = data_byte;
          HDR_CMAP_DEPTH:  palette_entry_bits_next = data_byte;
          HDR_WIDTH_LO:    width_reg_next[7:0] = data_byte;
          HDR_WIDTH_HI:    width_reg_next[15:8] = data_byte;
          HDR_HEIGHT_LO:   height_reg_next[7:0] = data_byte;
          HDR_HEIGHT_HI:   height_reg_next[15:8] = data_byte;
          HDR_DEPTH: begin
            pixel_depth_next = data_byte;
            pixel_total_next = pixel_prod;
            skip_total_next  = {13'd0, id_field_length} + skip_prod;
          end
          default: ;
        endcase
        if (e_header_index < HDR_LAST) begin
          header_index_next = e_header_index + 5'd1;
        end else if (!depth_ok) begin
          have       = 1'b1;
          last       = 1'b1;
          st         = tga_dec_pkg::ST_BAD_DEPTH;
          phase_next = PH_DONE;
        end else begin
          pixels_left_next = pixel_total;
          if (pixel_total == 32'd0) begin
            have       = 1'b1;
            last       = 1'b1;
            phase_next = PH_DONE;
          end else begin
            skip_remaining_next = skip_total;
            phase_next          = (skip_total != 21'd0) ? PH_SKIP : pix_phase;
          end
        end
      end
      PH_SKIP: begin
        skip_remaining_next = e_skip_remaining - 21'd1;
        if (e_skip_remaining == 21'd1) begin
          phase_next = pix_phase;
        end
      end
      PH_PACKET: begin
        packet_left_next = pkt_len;
        if ({24'd0, pkt_len} > e_pixels_left) begin
          packet_left_next = e_pixels_left[7:0];
        end
        packet_is_run_next    = data_byte[7];
        color_assembly_next   = 32'd0;
        color_byte_index_next = 2'd0;
        phase_next            = PH_RLE_PIXEL;
      end
      PH_PIXEL, PH_RLE_PIXEL: begin
        if (pix_done) begin
          if (e_pixel_depth == DEPTH_16) begin
            b_val = {asm_word[4:0], 3'b000};
            g_val = {asm_word[9:5], 3'b000};
            r_val = {asm_word[14:10], 3'b000};
          end else begin
            b_val = asm_word[7:0];
            g_val = asm_word[15:8];
            r_val = asm_word[23:16];
            a_val = (e_pixel_depth == DEPTH_32) ? asm_word[31:24] : 8'd0;
          end
          color_assembly_next   = 32'd0;
          color_byte_index_next = 2'd0;
          have                  = 1'b1;
          if (e_phase == PH_RLE_PIXEL && e_packet_is_run) begin
            cnt              = e_packet_left;
            pixels_left_next = e_pixels_left - {24'd0, e_packet_left};
            packet_left_next = 8'd0;
          end else begin
            cnt              = 8'd1;
            pixels_left_next = e_pixels_left - 32'd1;
            if (e_phase == PH_RLE_PIXEL) begin
              packet_left_next = e_packet_left - 8'd1;
            end
          end
          if (e_phase == PH_RLE_PIXEL && packet_left_next == 8'd0) begin
            phase_next = PH_PACKET;
          end
          if (pixels_left_next == 32'd0) begin
            last       = 1'b1;
            phase_next = PH_DONE;
          end
        end else begin
          color_assembly_next   = asm_word;
          color_byte_index_next = e_color_byte_index + 2'd1;
        end
      end
      default: ;
    endcase

    // early end of file; a pixel finished by this byte rides along
    if (file_end && (e_phase != PH_DONE) && (phase_next != PH_DONE)) begin
      have       = 1'b1;
      last       = 1'b1;
      st         = tga_dec_pkg::ST_TRUNCATED;
      phase_next = PH_DONE;
    end
  end

  assign res_valid = take && have;

  always_comb begin
    res.red           = r_val;
    res.green         = g_val;
    res.blue          = b_val;
    res.alpha         = a_val;
    res.run_count     = cnt;
    res.last_pixel    = last;
    res.status        = st;
    res.image_width   = width_reg_next;
    res.image_height  = height_reg_next;
    res.channel_count = (pixel_depth_next == DEPTH_32) ? tga_dec_pkg::CHANNELS_RGBA
                                                       : tga_dec_pkg::CHANNELS_RGB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      header_index       <= 5'd0;
      id_field_length    <= 8'd0;
      compression_kind   <= 8'd0;
      palette_entries    <= 16'd0;
      palette_entry_bits <= 8'd0;
      width_reg          <= 16'd0;
      height_reg         <= 16'd0;
      pixel_depth        <= 8'd0;
      skip_remaining     <= 21'd0;
      pixels_left        <= 32'd0;
      packet_left        <= 8'd0;
      packet_is_run      <= 1'b0;
      color_assembly     <= 32'd0;
      color_byte_index   <= 2'd0;
    end else if (take) begin
      phase              <= phase_next;
      header_index       <= header_index_next;
      id_field_length    <= id_field_length_next;
      compression_kind   <= compression_kind_next;
      palette_entries    <= palette_entries_next;
      palette_entry_bits <= palette_entry_bits_next;
      width_reg          <= width_reg_next;
      height_reg         <= height_reg_next;
      pixel_depth        <= pixel_depth_next;
      skip_remaining     <= skip_remaining_next;
      pixels_left        <= pixels_left_next;
      packet_left        <= packet_left_next;
      packet_is_run      <= packet_is_run_next;
      color_assembly     <= color_assembly_next;
      color_byte_index   <= color_byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_total <= pixel_total_next;
      skip_total  <= skip_total_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/tga_dec_outbuf.sv -----
// ----------------------------------------------------------------------------
// TGA decoder output buffer
// Result register with a skid stage so input keeps flowing under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_dec_outbuf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire tga_dec_pkg::result_t in_data,
  output logic                      space,
  output logic                      out_valid,
  output tga_dec_pkg::result_t      out_data,
  input  wire logic                 out_ready
);

  logic                 skid_valid;
  tga_dec_pkg::result_t skid_data;

  // skid only fills while the output is stalled, so in_valid is low when it holds
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/tga_image_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// TGA image stream decoder
// Byte-stream TGA parser emitting RGB(A) pixels and RLE run counts.
// ----------------------------------------------------------------------------
// Each result is registered in the output stage, via the skid stage if m_* is stalled.
// Throughput: one byte per cycle while s_tready is high; the state update is a single pass per byte.
// s_tready falls only when both the result register and skid stage are full.
// Reset: rst (synchronous, high) returns the parser to header byte 0 and
// empties the output stage; s_tuser (new file) does the same for the parser.
`default_nettype none

module tga_image_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // file_end
  input  wire logic [0:0]  s_tuser,   // [0] frame_start
  // pixel output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                      // [31:24] alpha, [39:32] run_count,
                                      // [55:40] image_width, [71:56] image_height,
                                      // [74:72] channel_count, [79:75] zero
  output logic             m_tlast,   // last_pixel
  output logic [1:0]       m_tuser    // [1:0] status
);

  logic                 take;
  logic                 res_valid;
  tga_dec_pkg::result_t res;
  tga_dec_pkg::result_t out_res;

  // a byte transaction completes on valid and ready together
  assign take = s_tvalid && s_tready;

  // parser: all per-byte state and the result it produces
  tga_dec_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (s_tdata),
    .frame_start (s_tuser[0]),
    .file_end    (s_tlast),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register plus skid, decoupling the two sides
  tga_dec_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  // pack the result fields onto the stream
  assign m_tdata = {5'd0,
                    out_res.channel_count,
                    out_res.image_height,
                    out_res.image_width,
                    out_res.run_count,
                    out_res.alpha,
                    out_res.blue,
                    out_res.green,
                    out_res.red};
  assign m_tlast = out_res.last_pixel;
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire

// ----- src/tga_dec_checker.sv -----
// ----------------------------------------------------------------------------
// TGA decoder port checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tga_image_stream_decoder_top_defines.svh"

module tga_dec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tlast,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [1:0]  m_tuser
);

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tlast ^ s_tuser[0] ^ (^s_tdata);

  // stalled result holds
  `TGA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped under stall")

  // input backs off only while a result is waiting
  `TGA_ASSERT_NOW(a_ready, !s_tready, m_tvalid, "input stalled with empty output")

  // any error status ends the file
  `TGA_ASSERT_NOW(a_err_last, m_tvalid && (m_tuser != tga_dec_pkg::ST_OK), m_tlast, "error without last")

  // a result with no pixel only ever closes a file
  `TGA_ASSERT_NOW(a_empty_last, m_tvalid && (m_tdata[39:32] == 8'd0), m_tlast, "empty result not last")

  // channel count is 3 or 4
  `TGA_ASSERT_NOW(a_chan, m_tvalid, (m_tdata[74:72] == tga_dec_pkg::CHANNELS_RGB) || (m_tdata[74:72] == tga_dec_pkg::CHANNELS_RGBA), "bad channel count")

endmodule

bind tga_image_stream_decoder_top tga_dec_checker u_tga_dec_checker (.*);

`default_nettype wire

// ----- tb/tga_pixel_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// TGA decoder pixel scoreboard
// Byte-level decoder model that predicts result transactions, plus the
// in-order comparison of what the decoder actually emits.
// ----------------------------------------------------------------------------
package tga_pixel_sb_pkg;
  import tga_dec_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PACKET,
    PH_RLE_PIXEL,
    PH_DONE
  } dec_phase_e;

  localparam logic [7:0] TGA_TYPE_TRUECOLOUR = 8'd2;
  localparam logic [7:0] TGA_TYPE_GREY       = 8'd3;
  localparam logic [7:0] TGA_TYPE_RLE        = 8'd10;
  localparam logic [4:0] HDR_LAST_BYTE       = 5'd17;
  localparam logic [7:0] DEPTH_16            = 8'd16;
  localparam logic [7:0] DEPTH_24            = 8'd24;
  localparam logic [7:0] DEPTH_32            = 8'd32;

  class tga_pixel_scoreboard;
    dec_phase_e  phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  id_len, img_type, entry_bits, depth;
    logic [15:0] pal_entries, width, height;
    int unsigned skip_left, pix_left;
    logic [7:0]  pkt_left;
    bit          pkt_run;
    logic [31:0] colour_acc;
    logic [1:0]  colour_idx;

    result_t     expected_q[$];
    int unsigned errors, n_bytes, n_results, n_runs;
    int unsigned n_status[4];

    function new();
      clear();
      errors = 0;
      n_bytes = 0;
      n_results = 0;
      n_runs = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void clear();
      phase = PH_HEADER;
      hdr_idx = '0;
      id_len = '0;
      img_type = '0;
      entry_bits = '0;
      depth = '0;
      pal_entries = '0;
      width = '0;
      height = '0;
      skip_left = 0;
      pix_left = 0;
      pkt_left = '0;
      pkt_run = 1'b0;
      colour_acc = '0;
      colour_idx = '0;
    endfunction

    function dec_phase_e pixel_phase();
      return (img_type == TGA_TYPE_RLE) ? PH_PACKET : PH_PIXEL;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // One accepted input transaction: advance the decoder and queue any result.
    function void note_byte(logic [7:0] b, bit fs, bit fe);
      result_t    px;
      bit         have, was_done, rle;
      logic [7:0] bpp;
      logic [31:0] v;
      px = '0;
      have = 1'b0;
      n_bytes++;
      if (fs) clear();
      was_done = (phase == PH_DONE);
      case (phase)
        PH_HEADER: begin
          case (hdr_idx)
            5'd0:  id_len = b;
            5'd1:  if (b != 8'd0) begin
                     have = 1'b1;
                     px.last_pixel = 1'b1;
                     px.status = ST_COLOR_MAPPED;
                     phase = PH_DONE;
                   end
            5'd2:  img_type = b;
            5'd5:  pal_entries[7:0] = b;
            5'd6:  pal_entries[15:8] = b;
            5'd7:  entry_bits = b;
            5'd12: width[7:0] = b;
            5'd13: width[15:8] = b;
            5'd14: height[7:0] = b;
            5'd15: height[15:8] = b;
            5'd16: depth = b;
            default: ;
          endcase
          if (hdr_idx < HDR_LAST_BYTE) begin
            hdr_idx++;
          end else begin
            rle = (img_type == TGA_TYPE_RLE);
            if (!(depth == DEPTH_24 || depth == DEPTH_32 || (!rle && depth == DEPTH_16))) begin
              have = 1'b1;
              px.last_pixel = 1'b1;
              px.status = ST_BAD_DEPTH;
              phase = PH_DONE;
            end else begin
              pix_left = 32'(width) * 32'(height);
              if (pix_left == 0) begin
                have = 1'b1;
                px.last_pixel = 1'b1;
                phase = PH_DONE;
              end else begin
                skip_left = 32'(id_len) + 32'(pal_entries) * 32'(entry_bits >> 3);
                phase = (skip_left != 0) ? PH_SKIP : pixel_phase();
              end
            end
          end
        end
        PH_SKIP: begin
          skip_left--;
          if (skip_left == 0) phase = pixel_phase();
        end
        PH_PACKET: begin
          if (b < 8'd128) begin
            pkt_left = b + 8'd1;
            pkt_run = 1'b0;
          end else begin
            pkt_left = b - 8'd127;
            pkt_run = 1'b1;
          end
          if (32'(pkt_left) > pix_left) pkt_left = pix_left[7:0];
          colour_acc = '0;
          colour_idx = '0;
          phase = PH_RLE_PIXEL;
        end
        PH_PIXEL, PH_RLE_PIXEL: begin
          bpp = depth >> 3;
          colour_acc = colour_acc | (32'(b) << {colour_idx, 3'b000});
          if (32'(colour_idx) + 1 >= 32'(bpp)) begin
            v = colour_acc;
            if (depth == DEPTH_16) begin
              px.blue  = {v[4:0], 3'b000};
              px.green = {v[9:5], 3'b000};
              px.red   = {v[14:10], 3'b000};
            end else begin
              px.blue  = v[7:0];
              px.green = v[15:8];
              px.red   = v[23:16];
              px.alpha = (depth == DEPTH_32) ? v[31:24] : 8'd0;
            end
            colour_acc = '0;
            colour_idx = '0;
            have = 1'b1;
            if (phase == PH_PIXEL) begin
              px.run_count = 8'd1;
              pix_left--;
            end else if (pkt_run) begin
              px.run_count = pkt_left;
              pix_left -= 32'(pkt_left);
              pkt_left = '0;
            end else begin
              px.run_count = 8'd1;
              pix_left--;
              pkt_left--;
            end
            if (phase == PH_RLE_PIXEL && pkt_left == 8'd0) phase = PH_PACKET;
            if (pix_left == 0) begin
              px.last_pixel = 1'b1;
              phase = PH_DONE;
            end
          end else begin
            colour_idx++;
          end
        end
        default: ;
      endcase

      // file end while the image is still open
      if (fe && !was_done && phase != PH_DONE) begin
        have = 1'b1;
        px.last_pixel = 1'b1;
        px.status = ST_TRUNCATED;
        phase = PH_DONE;
      end

      if (have) begin
        px.image_width = width;
        px.image_height = height;
        px.channel_count = (depth == DEPTH_32) ? CHANNELS_RGBA : CHANNELS_RGB;
        expected_q.push_back(px);
      end
    endfunction

    function void field_eq(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    // One accepted output transaction, compared with the oldest prediction.
    function void check_pixel(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: run_count %0d status %0d",
               got.run_count, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (want.run_count > 8'd1) n_runs++;
      n_status[want.status]++;
      field_eq("red", want.red, got.red);
      field_eq("green", want.green, got.green);
      field_eq("blue", want.blue, got.blue);
      field_eq("alpha", want.alpha, got.alpha);
      field_eq("run_count", want.run_count, got.run_count);
      field_eq("last_pixel", want.last_pixel, got.last_pixel);
      field_eq("status", want.status, got.status);
      field_eq("image_width", want.image_width, got.image_width);
      field_eq("image_height", want.image_height, got.image_height);
      field_eq("channel_count", want.channel_count, got.channel_count);
    endfunction
  endclass

endpackage

// ----- tb/tb_tga_image_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// TGA image stream decoder testbench
// Feeds whole TGA files, directed corner cases then random ones, through the
// byte stream with random gaps and back-pressure, and checks every pixel
// transaction against a byte-level prediction of the decoder.
// ----------------------------------------------------------------------------
module tb_tga_image_stream_decoder_top;
  import tga_dec_pkg::*;
  import tga_pixel_sb_pkg::*;

  // one file byte as it travels on the slave side
  typedef struct packed {
    logic [7:0] data;
    logic       fs;
    logic       fe;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  tga_pixel_scoreboard sb = new();

  file_byte_t  stim[$];          // bytes of the file being built, sent in order
  int unsigned tx_gap_max = 15;  // sender idle range per transaction
  int unsigned rx_gap_max = 15;  // receiver idle range per transaction
  int unsigned hold_cycles = 0;  // one-off long receiver hold-off
  int unsigned n_items = 0;

  tga_image_stream_decoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // File building (zero time)
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_byte(logic [7:0] b, bit fs, bit fe);
    file_byte_t it;
    it.data = b;
    it.fs = fs;
    it.fe = fe;
    stim.push_back(it);
    n_items++;
  endfunction

  // 18-byte header followed by the ID field and colour-map bytes it implies.
  // Fields the decoder ignores (map origin, image origin, descriptor) get noise.
  function automatic void put_header(logic [7:0] id_len, logic [7:0] cmap,
                                     logic [7:0] itype, logic [15:0] pal_n,
                                     logic [7:0] pal_bits, logic [15:0] w,
                                     logic [15:0] h, logic [7:0] depth, bit fs);
    put_byte(id_len, fs, 1'b0);
    put_byte(cmap, 1'b0, 1'b0);
    put_byte(itype, 1'b0, 1'b0);
    repeat (2) put_byte(rand_byte(), 1'b0, 1'b0);
    put_byte(pal_n[7:0], 1'b0, 1'b0);
    put_byte(pal_n[15:8], 1'b0, 1'b0);
    put_byte(pal_bits, 1'b0, 1'b0);
    repeat (4) put_byte(rand_byte(), 1'b0, 1'b0);
    put_byte(w[7:0], 1'b0, 1'b0);
    put_byte(w[15:8], 1'b0, 1'b0);
    put_byte(h[7:0], 1'b0, 1'b0);
    put_byte(h[15:8], 1'b0, 1'b0);
    put_byte(depth, 1'b0, 1'b0);
    put_byte(rand_byte(), 1'b0, 1'b0);
    repeat (int'(id_len) + int'(pal_n) * int'(pal_bits >> 3))
      put_byte(rand_byte(), 1'b0, 1'b0);
  endfunction

  // Pixel data with random colours; RLE packets now and then ask for more
  // pixels than remain so the clamp gets exercised.
  function automatic void put_pixels(int unsigned n, int unsigned bpp, bit rle);
    int unsigned left, cnt, eff;
    bit run;
    if (!rle) begin
      repeat (n * bpp) put_byte(rand_byte(), 1'b0, 1'b0);
      return;
    end
    left = n;
    while (left > 0) begin
      cnt = $urandom_range(1, (left < 128) ? left : 128);
      if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, 128);
      run = 1'($urandom_range(0, 1));
      put_byte(run ? 8'(cnt + 127) : 8'(cnt - 1), 1'b0, 1'b0);
      eff = (cnt > left) ? left : cnt;
      repeat (run ? bpp : eff * bpp) put_byte(rand_byte(), 1'b0, 1'b0);
      left -= eff;
    end
  endfunction

  // Shorten the file to n bytes, optionally flagging the new last byte as end.
  function automatic void cut_at(int unsigned n, bit with_end);
    while (stim.size() > n) stim.delete(stim.size() - 1);
    if (with_end && stim.size() > 0) stim[stim.size() - 1].fe = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Slave-side driver: one transaction per queued byte, random gap before each.
  // tvalid stays high across back-to-back bytes and is only lowered for a gap.
  // ---------------------------------------------------------------------------
  task automatic send_queued();
    file_byte_t  it;
    int unsigned gap;
    while (stim.size() > 0) begin
      it = stim.pop_front();
      gap = $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= it.data;
      s_tuser  <= it.fs;
      s_tlast  <= it.fe;
      @(posedge clk);
      while (s_tready !== 1'b1) @(posedge clk);
      sb.note_byte(it.data, it.fs, it.fe);
    end
  endtask

  // Sender goes quiet until every predicted pixel has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Master-side sink: random ready gaps, plus the single long hold-off asked
  // for by the stimulus. Each accepted transaction is unpacked and checked.
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    int unsigned gap;
    result_t     got;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rx_gap_max);
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      got.red           = m_tdata[7:0];
      got.green         = m_tdata[15:8];
      got.blue          = m_tdata[23:16];
      got.alpha         = m_tdata[31:24];
      got.run_count     = m_tdata[39:32];
      got.image_width   = m_tdata[55:40];
      got.image_height  = m_tdata[71:56];
      got.channel_count = m_tdata[74:72];
      got.last_pixel    = m_tlast;
      got.status        = status_t'(m_tuser);
      sb.check_pixel(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind, end_mode, bpp;
    logic [15:0] w, h, pal_n;
    logic [7:0]  depth, itype, id_len, pal_bits, cmap;
    bit          rle, pressure_done;
    pressure_done = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed files ---

    // straight after reset, no new-file flag: bytes are still a header.
    // 24-bit truecolour, all-zero then all-ones pixel
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd2, 16'd1, DEPTH_24, 1'b0);
    repeat (3) put_byte(8'h00, 1'b0, 1'b0);
    repeat (2) put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b1);
    send_queued();

    // 32-bit with a 3-byte ID field; alpha comes through
    put_header(8'd3, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd1, 16'd2, DEPTH_32, 1'b1);
    repeat (4) put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'h12, 1'b0, 1'b0);
    put_byte(8'h34, 1'b0, 1'b0);
    put_byte(8'h56, 1'b0, 1'b0);
    put_byte(8'h78, 1'b0, 1'b1);
    send_queued();

    // 16-bit little-endian 5:5:5, non-RLE type other than truecolour
    put_header(8'd0, 8'd0, TGA_TYPE_GREY, 16'd0, 8'd0, 16'd3, 16'd1, DEPTH_16, 1'b1);
    put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'h1F, 1'b0, 1'b0);
    put_byte(8'h7C, 1'b0, 1'b1);
    send_queued();

    // spurious colour map in an uncolour-mapped file: 1 ID byte + 2*3 map bytes
    put_header(8'd1, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd2, 8'd24, 16'd1, 16'd1, DEPTH_24, 1'b1);
    put_pixels(1, 3, 1'b0);
    cut_at(stim.size(), 1'b1);
    send_queued();

    // colour-mapped rejects at header byte 1; further ends are ignored
    put_header(8'd0, 8'd1, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd1, 16'd1, DEPTH_24, 1'b1);
    put_byte(rand_byte(), 1'b0, 1'b1);
    put_byte(rand_byte(), 1'b0, 1'b1);
    send_queued();
    put_header(8'd0, 8'hFF, TGA_TYPE_RLE, 16'd0, 8'd0, 16'd4, 16'd4, DEPTH_32, 1'b1);
    cut_at(stim.size(), 1'b1);
    send_queued();

    // unsupported depths: 8-bit truecolour, 16-bit RLE
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd1, 16'd1, 8'd8, 1'b1);
    put_byte(rand_byte(), 1'b0, 1'b1);
    send_queued();
    put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd0, 8'd0, 16'd1, 16'd1, DEPTH_16, 1'b1);
    put_byte(rand_byte(), 1'b0, 1'b1);
    send_queued();

    // empty images at the width/height extremes; trailing bytes ignored
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd0, 16'd5, DEPTH_24, 1'b1);
    put_byte(rand_byte(), 1'b0, 1'b0);
    put_byte(rand_byte(), 1'b0, 1'b1);
    send_queued();
    put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd0, 8'd0, 16'hFFFF, 16'd0, DEPTH_32, 1'b1);
    send_queued();

    // RLE run of 128 clamped to the 4 pixels of a 2x2 image, junk after
    put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd0, 8'd0, 16'd2, 16'd2, DEPTH_24, 1'b1);
    put_byte(8'hFF, 1'b0, 1'b0);
    repeat (3) put_byte(rand_byte(), 1'b0, 1'b0);
    put_byte(rand_byte(), 1'b0, 1'b0);
    put_byte(rand_byte(), 1'b0, 1'b1);
    send_queued();

    // RLE raw packet of 128 clamped to 3 pixels, 32-bit
    put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd0, 8'd0, 16'd3, 16'd1, DEPTH_32, 1'b1);
    put_byte(8'h7F, 1'b0, 1'b0);
    put_pixels(3, 4, 1'b0);
    cut_at(stim.size(), 1'b1);
    send_queued();

    // raw packet of one pixel, then a run of three
    put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd0, 8'd0, 16'd4, 16'd1, DEPTH_24, 1'b1);
    put_byte(8'h00, 1'b0, 1'b0);
    put_pixels(1, 3, 1'b0);
    put_byte(8'h82, 1'b0, 1'b0);
    put_pixels(1, 3, 1'b0);
    cut_at(stim.size(), 1'b1);
    send_queued();

    // early end in the middle of a pixel
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd2, 16'd1, DEPTH_24, 1'b1);
    put_byte(8'hA5, 1'b0, 1'b0);
    put_byte(8'h5A, 1'b0, 1'b1);
    send_queued();

    // early end on the byte that completes a pixel: pixel and status together
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd2, 16'd1, DEPTH_24, 1'b1);
    put_byte(8'h01, 1'b0, 1'b0);
    put_byte(8'h02, 1'b0, 1'b0);
    put_byte(8'h03, 1'b0, 1'b1);
    send_queued();

    // file end inside the header
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd2, 16'd1, DEPTH_24, 1'b1);
    cut_at(9, 1'b1);
    send_queued();

    // new file flag arrives mid-image; the next file simply takes over
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd4, 16'd1, DEPTH_24, 1'b1);
    put_pixels(2, 3, 1'b0);
    cut_at(stim.size() - 1, 1'b0);
    send_queued();

    // widest image, truncated after three pixels
    put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'hFFFF, 16'd1, DEPTH_24, 1'b1);
    put_pixels(3, 3, 1'b0);
    cut_at(stim.size(), 1'b1);
    send_queued();

    // longest ID field; huge map count with sub-byte entries adds no skip
    put_header(8'hFF, 8'd0, TGA_TYPE_TRUECOLOUR, 16'hFFFF, 8'd7, 16'd1, 16'd1, DEPTH_24, 1'b1);
    put_pixels(1, 3, 1'b0);
    cut_at(stim.size(), 1'b1);
    send_queued();

    drain_results();

    // --- random files ---
    n_items = 0;
    while (n_items < 2000) begin
      kind = $urandom_range(0, 99);
      // some files go through with no idling on one or both sides
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;

      if (kind < 10) begin
        // noise: random bytes and flags
        put_byte(rand_byte(), 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 23))
          put_byte(rand_byte(), $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
      end else begin
        rle = 1'($urandom_range(0, 1));
        if (rle) begin
          itype = TGA_TYPE_RLE;
          depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
        end else begin
          itype = TGA_TYPE_TRUECOLOUR;
          if ($urandom_range(0, 3) == 0) begin
            itype = rand_byte();
            if (itype == TGA_TYPE_RLE) itype = TGA_TYPE_GREY;
          end
          case ($urandom_range(0, 2))
            0: depth = DEPTH_16;
            1: depth = DEPTH_24;
            default: depth = DEPTH_32;
          endcase
        end
        case ($urandom_range(0, 9))
          0: begin
            w = 16'($urandom_range(20, 60));
            h = 16'd1;
          end
          1: begin
            // empty image with a random other dimension
            w = 16'($urandom_range(0, 65535));
            h = 16'd0;
            if ($urandom_range(0, 1)) begin
              h = w;
              w = 16'd0;
            end
          end
          default: begin
            w = 16'($urandom_range(1, 4));
            h = 16'($urandom_range(1, 4));
          end
        endcase
        id_len = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 8)) : 8'd0;
        case ($urandom_range(0, 4))
          0: begin
            pal_n = 16'($urandom_range(0, 65535));
            pal_bits = 8'($urandom_range(0, 7));
          end
          1: begin
            pal_n = 16'($urandom_range(1, 3));
            pal_bits = rand_byte();
          end
          default: begin
            pal_n = 16'd0;
            pal_bits = rand_byte();
          end
        endcase
        cmap = 8'd0;

        if (kind >= 80 && kind < 90) begin
          // rejected files: colour-mapped or unsupported depth
          if ($urandom_range(0, 1)) begin
            cmap = 8'($urandom_range(1, 255));
          end else if (rle && $urandom_range(0, 1)) begin
            depth = DEPTH_16;
          end else begin
            do depth = rand_byte();
            while (depth == DEPTH_16 || depth == DEPTH_24 || depth == DEPTH_32);
          end
        end

        bpp = int'(depth >> 3);
        put_header(id_len, cmap, itype, pal_n, pal_bits, w, h, depth, 1'b1);
        if (kind < 80) put_pixels(int'(w) * int'(h), bpp, rle);

        end_mode = $urandom_range(0, 99);
        if (end_mode < 70) begin
          cut_at(stim.size(), 1'b1);
        end else if (end_mode < 85) begin
          cut_at($urandom_range(1, stim.size()), 1'b1);
        end else if (end_mode < 95) begin
          // broken off without an end flag; the next file interrupts it
          cut_at($urandom_range(1, stim.size()), 1'b0);
        end else begin
          put_byte(rand_byte(), 1'b0, 1'b0);
          put_byte(rand_byte(), 1'b0, 1'b1);
        end
      end
      send_queued();

      if ($urandom_range(0, 9) == 0) drain_results();

      // back-pressure: receiver stalls for a long stretch while a long image
      // streams in at full rate, so the output stage fills and input stalls
      if (!pressure_done && n_items > 1000) begin
        pressure_done = 1'b1;
        drain_results();
        tx_gap_max = 0;
        hold_cycles = 400;
        put_header(8'd0, 8'd0, TGA_TYPE_TRUECOLOUR, 16'd0, 8'd0, 16'd64, 16'd1,
                   DEPTH_24, 1'b1);
        put_pixels(64, 3, 1'b0);
        cut_at(stim.size(), 1'b1);
        send_queued();
        drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d file bytes, %0d result transactions, %0d runs longer than a pixel",
             sb.n_bytes, sb.n_results, sb.n_runs);
    $display("Endings: %0d ok, %0d colour-mapped, %0d unsupported depth, %0d truncated",
             sb.n_status[ST_OK], sb.n_status[ST_COLOR_MAPPED],
             sb.n_status[ST_BAD_DEPTH], sb.n_status[ST_TRUNCATED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/tga_dec_pkg.sv
src/tga_dec_core.sv
src/tga_dec_outbuf.sv
src/tga_image_stream_decoder_top.sv
src/tga_dec_checker.sv
tb/tga_pixel_sb_pkg.sv
tb/tb_tga_image_stream_decoder_top.sv
